@@ rtl/ggc_pkg.sv @@
// ----------------------------------------------------------------------------
// ggc_pkg
// Types, constants and helpers used by the go-to-goal controller.
// ----------------------------------------------------------------------------
package ggc_pkg;

	localparam int GUARD_BITS = 4;
	localparam int DXY_W      = 17;
	localparam int XY_W       = 24;
	localparam int Z_W        = 20;
	localparam int DIFF_W     = 21;
	localparam int PROD_W     = 41;
	localparam int DIST_W     = 18;
	localparam int GAIN_W     = 12;
	localparam int ACC_W      = 36;
	localparam int OUT_W      = 24;
	localparam int TABLE_LEN  = 24;

	localparam logic signed [Z_W-1:0] HALF_PI_Q16  = 20'sd102944;
	localparam logic        [16:0]    INV_GAIN_Q16 = 17'd39797;

	localparam logic signed [ACC_W-1:0] OUT_MAX = 36'sd8388607;
	localparam logic signed [ACC_W-1:0] OUT_MIN = -36'sd8388608;

	typedef enum logic [2:0] {
		REG_GOAL_X      = 3'd0,
		REG_GOAL_Y      = 3'd1,
		REG_ARRIVE_TOL  = 3'd2,
		REG_LINEAR_GAIN = 3'd3,
		REG_HEADING_GAIN = 3'd4
	} cfg_reg_t;

	// atan(2^-i) in Q.16 radians, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		case (i)
			0:       return 20'sd51472;
			1:       return 20'sd30386;
			2:       return 20'sd16055;
			3:       return 20'sd8150;
			4:       return 20'sd4091;
			5:       return 20'sd2047;
			6:       return 20'sd1024;
			7:       return 20'sd512;
			8:       return 20'sd256;
			9:       return 20'sd128;
			10:      return 20'sd64;
			11:      return 20'sd32;
			12:      return 20'sd16;
			13:      return 20'sd8;
			14:      return 20'sd4;
			15:      return 20'sd2;
			16:      return 20'sd1;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		if (v > OUT_MAX) begin
			return OUT_MAX[OUT_W-1:0];
		end else if (v < OUT_MIN) begin
			return OUT_MIN[OUT_W-1:0];
		end else begin
			return v[OUT_W-1:0];
		end
	endfunction

endpackage

@@ rtl/go_to_goal_controller.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_controller
// Proportional go-to-goal law: pose in, distance and bearing by a pipelined
// CORDIC, linear and angular drive out.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  pose      start / busy       pose_x, pose_y, pose_heading
//  command   done (strobe)      linear_velocity, angular_velocity, arrived
//  config    cfg_we             cfg_index, cfg_data
//
//  One pose enters every cycle; busy stays low.
//  From accept to the done strobe a pose passes through pre-rotation, one
//  stage per micro-rotation, gain scale, distance round, gain multiply, and
//  round/saturate into the output register.
//  Reset clears the valid bits and loads the default register values.
//  The receiver cannot stall; each command is shown for one cycle.
// ----------------------------------------------------------------------------
module go_to_goal_controller #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  pose_x,
	input  logic signed [15:0]  pose_y,
	input  logic signed [15:0]  pose_heading,
	output logic                done,
	output logic signed [23:0]  linear_velocity,
	output logic signed [23:0]  angular_velocity,
	output logic                arrived,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import ggc_pkg::*;

	logic signed [15:0]     goal_x_q, goal_y_q;
	logic [15:0]            arrive_tol_q;
	logic [GAIN_W-1:0]      linear_gain_q, heading_gain_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q       <= '0;
			goal_y_q       <= '0;
			arrive_tol_q   <= 16'd3;
			linear_gain_q  <= 12'd256;
			heading_gain_q <= 12'd1024;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GOAL_X:       goal_x_q       <= cfg_data;
				REG_GOAL_Y:       goal_y_q       <= cfg_data;
				REG_ARRIVE_TOL:   arrive_tol_q   <= cfg_data;
				REG_LINEAR_GAIN:  linear_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_HEADING_GAIN: heading_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---- stage 1: displacement and pre-rotation into the right half plane
	logic signed [DXY_W-1:0] dx, dy;
	logic signed [XY_W-1:0]  x0, y0, x_pre, y_pre;
	logic signed [Z_W-1:0]   z_pre;

	assign dx = $signed({goal_x_q[15], goal_x_q}) - $signed({pose_x[15], pose_x});
	assign dy = $signed({goal_y_q[15], goal_y_q}) - $signed({pose_y[15], pose_y});
	assign x0 = XY_W'($signed({dx, {GUARD_BITS{1'b0}}}));
	assign y0 = XY_W'($signed({dy, {GUARD_BITS{1'b0}}}));

	always_comb begin
		x_pre = x0;
		y_pre = y0;
		z_pre = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				x_pre = y0;
				y_pre = -x0;
				z_pre = HALF_PI_Q16;
			end else begin
				x_pre = -y0;
				y_pre = x0;
				z_pre = -HALF_PI_Q16;
			end
		end
	end

	// CORDIC pipeline: entry 0 is stage 1, entry k is after micro-rotation k
	logic                   vld_s  [0:CORDIC_STAGES];
	logic signed [XY_W-1:0] cx_s   [0:CORDIC_STAGES];
	logic signed [XY_W-1:0] cy_s   [0:CORDIC_STAGES];
	logic signed [Z_W-1:0]  cz_s   [0:CORDIC_STAGES];
	logic signed [15:0]     ph_s   [0:CORDIC_STAGES];
	logic                   zero_s [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= x_pre;
		cy_s[0]   <= y_pre;
		cz_s[0]   <= z_pre;
		ph_s[0]   <= pose_heading;
		zero_s[0] <= (dx == '0) && (dy == '0);
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
		logic signed [XY_W-1:0] xs, ys;

		assign xs = cx_s[k] >>> k;
		assign ys = cy_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (cy_s[k] >= 0) begin
				cx_s[k+1] <= cx_s[k] + ys;
				cy_s[k+1] <= cy_s[k] - xs;
				cz_s[k+1] <= cz_s[k] + atan_q16(k);
			end else begin
				cx_s[k+1] <= cx_s[k] - ys;
				cy_s[k+1] <= cy_s[k] + xs;
				cz_s[k+1] <= cz_s[k] - atan_q16(k);
			end
			ph_s[k+1]   <= ph_s[k];
			zero_s[k+1] <= zero_s[k];
		end
	end

	// ---- stage 2: remove CORDIC gain, form heading error
	logic                     vld_s2, vld_s3, vld_s4;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DIFF_W-1:0] diff_s2, diff_s3;
	logic                     zero_s2;
	logic signed [PROD_W-1:0] prod_rnd;
	logic [DIST_W-1:0]        dist_s3;
	logic                     arrived_s4;
	logic [DIST_W+GAIN_W-1:0] lin_prod;
	logic signed [ACC_W-1:0]  lin_acc_s4, ang_acc_s4;
	logic signed [ACC_W-1:0]  lin_rnd, ang_rnd;

	assign prod_rnd = prod_s2 + PROD_W'(1 << (15 + GUARD_BITS));
	assign lin_prod = dist_s3 * linear_gain_q;
	assign lin_rnd  = (lin_acc_s4 + ACC_W'(128)) >>> 8;
	assign ang_rnd  = (ang_acc_s4 + ACC_W'(2048)) >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s2 <= vld_s[CORDIC_STAGES];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done   <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= cx_s[CORDIC_STAGES] * $signed({1'b0, INV_GAIN_Q16});
		diff_s2 <= DIFF_W'(cz_s[CORDIC_STAGES])
			- DIFF_W'($signed({ph_s[CORDIC_STAGES], 4'b0000}));
		zero_s2 <= zero_s[CORDIC_STAGES];

		// stage 3: round distance
		dist_s3 <= zero_s2 ? '0 : prod_rnd[16+GUARD_BITS+DIST_W-1:16+GUARD_BITS];
		diff_s3 <= diff_s2;

		// stage 4: arrival test and gain multiplies
		arrived_s4 <= ({{(DIST_W-16){1'b0}}, arrive_tol_q} >= dist_s3);
		lin_acc_s4 <= ACC_W'(lin_prod);
		ang_acc_s4 <= diff_s3 * $signed({1'b0, heading_gain_q});

		// output register: round, saturate, zero the drive on arrival
		arrived          <= arrived_s4;
		linear_velocity  <= arrived_s4 ? '0 : sat_out(lin_rnd);
		angular_velocity <= arrived_s4 ? '0 : sat_out(ang_rnd);
	end

endmodule

@@ rtl/ggc_checker.sv @@
// ----------------------------------------------------------------------------
// ggc_checker
// Port-level assertions for the go-to-goal controller, bound to the top level.
// ----------------------------------------------------------------------------
module ggc_checker #(
	parameter int CORDIC_STAGES = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [23:0] linear_velocity,
	input logic signed [23:0] angular_velocity,
	input logic               arrived
);
	localparam int LAT   = CORDIC_STAGES + 5;
	localparam int CNT_W = $clog2(LAT + 1);

	logic [CNT_W-1:0] warm_q;
	logic             warm;

	// count cycles since reset so latency checks only look at real accepts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CNT_W'(LAT)) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	assign warm = (warm_q == CNT_W'(LAT));

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("command strobe does not match accepted pose");

	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && arrived) |-> (linear_velocity == '0 && angular_velocity == '0))
		else $error("drive not zero on arrival");

	a_forward_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !arrived) |-> !linear_velocity[23])
		else $error("negative linear velocity");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		!warm |-> !done)
		else $error("command strobe before any pose could finish");

endmodule

bind go_to_goal_controller ggc_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_ggc_checker (.*);
